[rtl/lsfb_pkg.sv]
`default_nettype none
package lsfb_pkg;

    localparam int MAX_LEDS_DEF = 32;
    localparam int LED_COUNT_W  = 6;
    localparam int LED_IDX_W    = 5;
    localparam int CMD_W        = 3;
    localparam int LEVEL_W      = 8;
    localparam int BRI_W        = 5;
    localparam int COLOUR_W     = 3 * LEVEL_W;
    localparam int WORD_W       = 32;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_SET_COLOUR = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_SCALED = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_BRI    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ALL_BRI    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ALL_COLOUR = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REFRESH    = 3'd5;

    // register index (paddr[2])
    localparam logic REG_LED_COUNT = 1'b0;

    localparam logic [7:0]        LED_HDR    = 8'hE0;
    localparam logic [WORD_W-1:0] START_WORD = 32'h0000_0000;
    localparam logic [WORD_W-1:0] END_WORD   = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        OP_NONE       = 3'd0,
        OP_SET_COLOUR = 3'd1,
        OP_SET_BRI    = 3'd2,
        OP_ALL_COLOUR = 3'd3,
        OP_ALL_BRI    = 3'd4
    } t_op;

    // colour packing: red 23:16, green 15:8, blue 7:0
    typedef struct packed {
        t_op                    op;
        logic [LED_COUNT_W-1:0] idx;
        logic [COLOUR_W-1:0]    colour;
        logic [BRI_W-1:0]       bri;
        logic                   emit;
    } t_job;

    function automatic logic [WORD_W-1:0] led_word(input logic [BRI_W-1:0] bri,
                                                   input logic [COLOUR_W-1:0] colour);
        logic [7:0] hdr;
        hdr = LED_HDR | {3'b000, bri};
        return {hdr, colour[7:0], colour[15:8], colour[23:16]};
    endfunction

endpackage
`default_nettype wire

[rtl/lsfb_ram.sv]
`default_nettype none
module lsfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[rtl/lsfb_front.sv]
`default_nettype none
module lsfb_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_push,
    output logic                                  o_full,
    input  wire logic [lsfb_pkg::CMD_W-1:0]       i_command,
    input  wire logic [lsfb_pkg::LED_IDX_W-1:0]   i_led_index,
    input  wire logic [lsfb_pkg::LEVEL_W-1:0]     i_red_level,
    input  wire logic [lsfb_pkg::LEVEL_W-1:0]     i_green_level,
    input  wire logic [lsfb_pkg::LEVEL_W-1:0]     i_blue_level,
    input  wire logic [lsfb_pkg::LEVEL_W-1:0]     i_intensity,
    input  wire logic [lsfb_pkg::BRI_W-1:0]       i_brightness_level,
    input  wire logic                             i_emit_frame,
    input  wire logic [lsfb_pkg::LED_COUNT_W-1:0] i_led_count,
    output logic                                  o_job_valid,
    output lsfb_pkg::t_job                        o_job,
    input  wire logic                             i_job_pop
);
    localparam int LW = lsfb_pkg::LEVEL_W;

    lsfb_pkg::t_job r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    lsfb_pkg::t_job job;
    logic           keep;
    logic           in_range;
    logic [2*LW-1:0] prod_r, prod_g, prod_b;
    logic           wr;
    logic           rd;

    assign in_range = {1'b0, i_led_index} < i_led_count;
    assign prod_r   = i_red_level   * i_intensity;
    assign prod_g   = i_green_level * i_intensity;
    assign prod_b   = i_blue_level  * i_intensity;

    // decode command into a job for the back end
    always_comb begin
        job.op     = lsfb_pkg::OP_NONE;
        job.idx    = {1'b0, i_led_index};
        job.colour = {i_red_level, i_green_level, i_blue_level};
        job.bri    = i_brightness_level;
        job.emit   = i_emit_frame;
        keep       = 1'b1;
        case (i_command)
            lsfb_pkg::CMD_SET_COLOUR: begin
                if (in_range) job.op = lsfb_pkg::OP_SET_COLOUR;
            end
            lsfb_pkg::CMD_SET_SCALED: begin
                if (in_range) job.op = lsfb_pkg::OP_SET_COLOUR;
                job.colour = {prod_r[2*LW-1:LW], prod_g[2*LW-1:LW], prod_b[2*LW-1:LW]};
            end
            lsfb_pkg::CMD_SET_BRI: begin
                if (in_range) job.op = lsfb_pkg::OP_SET_BRI;
            end
            lsfb_pkg::CMD_ALL_BRI:    job.op = lsfb_pkg::OP_ALL_BRI;
            lsfb_pkg::CMD_ALL_COLOUR: job.op = lsfb_pkg::OP_ALL_COLOUR;
            lsfb_pkg::CMD_REFRESH:    job.emit = 1'b1;
            default:                  keep = 1'b0;
        endcase
        // nothing to update and nothing to send: drop
        if (job.op == lsfb_pkg::OP_NONE && !job.emit) keep = 1'b0;
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];
    assign wr          = i_push && !o_full && keep;
    assign rd          = i_job_pop && o_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= job;
        end
    end

endmodule
`default_nettype wire

[rtl/lsfb_back.sv]
`default_nettype none
module lsfb_back #(
    parameter int MAX_LEDS = lsfb_pkg::MAX_LEDS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic [lsfb_pkg::LED_COUNT_W-1:0] i_led_count,
    input  wire logic                             i_job_valid,
    input  wire lsfb_pkg::t_job                   i_job,
    output logic                                  o_job_pop,
    output logic                                  o_empty,
    input  wire logic                             i_pop,
    output logic [lsfb_pkg::WORD_W-1:0]           o_frame_word,
    output logic                                  o_last_word
);
    localparam int IW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CW = lsfb_pkg::LED_COUNT_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SWEEP = 5'b00010,
        S_START = 5'b00100,
        S_LED   = 5'b01000,
        S_END   = 5'b10000
    } t_state;

    t_state         r_state, n_state;
    lsfb_pkg::t_job r_job, n_job;
    logic [IW-1:0]  r_cnt, n_cnt;
    logic [MAX_LEDS-1:0] r_cval, r_bval;
    logic           r_rd_cv, r_rd_bv;

    // result buffer
    logic [lsfb_pkg::WORD_W-1:0] r_ob_word [2];
    logic                        r_ob_last [2];
    logic                        r_ob_wp, r_ob_rp;
    logic [1:0]                  r_ob_cnt;
    logic                        ob_full, ob_push, ob_pop, ob_last;
    logic [lsfb_pkg::WORD_W-1:0] ob_word;

    logic                          c_we, b_we, re;
    logic [IW-1:0]                 waddr, raddr;
    logic [lsfb_pkg::COLOUR_W-1:0] c_wdata, c_rdata, c_eff;
    logic [lsfb_pkg::BRI_W-1:0]    b_wdata, b_rdata, b_eff;
    logic [CW-1:0]                 last_idx;
    logic                          at_last;
    logic                          is_sweep;

    lsfb_ram #(.WIDTH(lsfb_pkg::COLOUR_W), .DEPTH(MAX_LEDS)) u_colour_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (waddr),
        .i_wdata (c_wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (c_rdata)
    );

    lsfb_ram #(.WIDTH(lsfb_pkg::BRI_W), .DEPTH(MAX_LEDS)) u_bri_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (waddr),
        .i_wdata (b_wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (b_rdata)
    );

    // never-written entries read as zero
    assign c_eff    = r_rd_cv ? c_rdata : '0;
    assign b_eff    = r_rd_bv ? b_rdata : '0;
    assign last_idx = i_led_count - CW'(1);
    assign at_last  = (CW'(r_cnt) == last_idx);
    assign ob_full  = (r_ob_cnt == 2'd2);
    assign is_sweep = (i_job.op == lsfb_pkg::OP_ALL_COLOUR) ||
                      (i_job.op == lsfb_pkg::OP_ALL_BRI);

    always_comb begin
        n_state   = r_state;
        n_job     = r_job;
        n_cnt     = r_cnt;
        o_job_pop = 1'b0;
        c_we      = 1'b0;
        b_we      = 1'b0;
        waddr     = r_cnt;
        c_wdata   = r_job.colour;
        b_wdata   = r_job.bri;
        re        = 1'b0;
        raddr     = '0;
        ob_push   = 1'b0;
        ob_word   = lsfb_pkg::START_WORD;
        ob_last   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_cnt     = '0;
                    waddr     = i_job.idx[IW-1:0];
                    c_wdata   = i_job.colour;
                    b_wdata   = i_job.bri;
                    c_we      = (i_job.op == lsfb_pkg::OP_SET_COLOUR);
                    b_we      = (i_job.op == lsfb_pkg::OP_SET_BRI);
                    if (is_sweep && i_led_count != '0) begin
                        n_state = S_SWEEP;
                    end else if (i_job.emit) begin
                        n_state = S_START;
                    end
                end
            end
            S_SWEEP: begin
                c_we = (r_job.op == lsfb_pkg::OP_ALL_COLOUR);
                b_we = (r_job.op == lsfb_pkg::OP_ALL_BRI);
                if (at_last) begin
                    n_state = r_job.emit ? S_START : S_IDLE;
                end else begin
                    n_cnt = r_cnt + IW'(1);
                end
            end
            S_START: begin
                if (!ob_full) begin
                    ob_push = 1'b1;
                    n_cnt   = '0;
                    if (i_led_count == '0) begin
                        n_state = S_END;
                    end else begin
                        re      = 1'b1;
                        n_state = S_LED;
                    end
                end
            end
            S_LED: begin
                if (!ob_full) begin
                    ob_push = 1'b1;
                    ob_word = lsfb_pkg::led_word(b_eff, c_eff);
                    if (at_last) begin
                        n_state = S_END;
                    end else begin
                        n_cnt = r_cnt + IW'(1);
                        re    = 1'b1;
                        raddr = r_cnt + IW'(1);
                    end
                end
            end
            S_END: begin
                if (!ob_full) begin
                    ob_push = 1'b1;
                    ob_word = lsfb_pkg::END_WORD;
                    ob_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign ob_pop       = i_pop && !o_empty;
    assign o_empty      = (r_ob_cnt == 2'd0);
    assign o_frame_word = r_ob_word[r_ob_rp];
    assign o_last_word  = r_ob_last[r_ob_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_cval   <= '0;
            r_bval   <= '0;
            r_rd_cv  <= 1'b0;
            r_rd_bv  <= 1'b0;
            r_ob_wp  <= 1'b0;
            r_ob_rp  <= 1'b0;
            r_ob_cnt <= 2'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (c_we) r_cval[waddr] <= 1'b1;
            if (b_we) r_bval[waddr] <= 1'b1;
            if (re) begin
                r_rd_cv <= r_cval[raddr];
                r_rd_bv <= r_bval[raddr];
            end
            if (ob_push) r_ob_wp <= ~r_ob_wp;
            if (ob_pop)  r_ob_rp <= ~r_ob_rp;
            r_ob_cnt <= r_ob_cnt + {1'b0, ob_push} - {1'b0, ob_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        if (ob_push) begin
            r_ob_word[r_ob_wp] <= ob_word;
            r_ob_last[r_ob_wp] <= ob_last;
        end
    end

endmodule
`default_nettype wire

[rtl/led_string_frame_builder.sv]
`default_nettype none
// Frame builder for a string of serial RGB LEDs. Commands come in
// through a push/full queue; each sets one LED's colour (plain or scaled by
// intensity as (c*i)>>8), one brightness, all brightnesses or all colours below
// led_count, or just refreshes. With emit_frame set, or on refresh, the block
// streams the frame out of a pop/empty queue: a zero start word, one word per
// LED {0xE0|brightness, blue, green, red}, then an all-ones end word flagged by
// last_word. Single-LED requests with an index at or above led_count change
// nothing; codes 6 and 7 are dropped. Structure: a front stage decodes a request
// and queues it (two deep); the back-end sequencer writes a single-LED update
// straight into the store, walks the store for a global update (one store
// entry written per cycle), and streams a frame at one word per cycle while
// the result queue has room, paced by the single read port of the LED store;
// a stalled result side holds the sequencer. led_count (APB address 0)
// saturates at MAX_LEDS and must only be written while the block is idle.
module led_string_frame_builder #(
    parameter int MAX_LEDS = lsfb_pkg::MAX_LEDS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // request queue
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [lsfb_pkg::CMD_W-1:0]          i_command,
    input  wire logic [lsfb_pkg::LED_IDX_W-1:0]      i_led_index,
    input  wire logic [lsfb_pkg::LEVEL_W-1:0]        i_red_level,
    input  wire logic [lsfb_pkg::LEVEL_W-1:0]        i_green_level,
    input  wire logic [lsfb_pkg::LEVEL_W-1:0]        i_blue_level,
    input  wire logic [lsfb_pkg::LEVEL_W-1:0]        i_intensity,
    input  wire logic [lsfb_pkg::BRI_W-1:0]          i_brightness_level,
    input  wire logic                                i_emit_frame,
    // result queue
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [lsfb_pkg::WORD_W-1:0]              o_frame_word,
    output logic                                     o_last_word,
    // APB register port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lsfb_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [lsfb_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lsfb_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                     pready
);
    localparam int CW = lsfb_pkg::LED_COUNT_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEDS);
    // reset count is 32, clipped to the store size
    localparam logic [CW-1:0] CNT_RST = CW'((MAX_LEDS < 32) ? MAX_LEDS : 32);

    logic [CW-1:0]  r_led_count, n_led_count;
    logic           cfg_wr;
    logic           job_valid;
    logic           job_pop;
    lsfb_pkg::t_job job;

    // ---- register port ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == lsfb_pkg::REG_LED_COUNT);
    assign n_led_count = (pwdata[CW-1:0] > MAX_CNT) ? MAX_CNT : pwdata[CW-1:0];
    assign prdata = (paddr[2] == lsfb_pkg::REG_LED_COUNT) ?
                    {{(lsfb_pkg::APB_DATA_W-CW){1'b0}}, r_led_count} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count <= CNT_RST;
        end else if (cfg_wr) begin
            r_led_count <= n_led_count;
        end
    end

    // ---- front: decode and queue requests ----
    lsfb_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (push),
        .o_full             (full),
        .i_command          (i_command),
        .i_led_index        (i_led_index),
        .i_red_level        (i_red_level),
        .i_green_level      (i_green_level),
        .i_blue_level       (i_blue_level),
        .i_intensity        (i_intensity),
        .i_brightness_level (i_brightness_level),
        .i_emit_frame       (i_emit_frame),
        .i_led_count        (r_led_count),
        .o_job_valid        (job_valid),
        .o_job              (job),
        .i_job_pop          (job_pop)
    );

    // ---- back: store updates and frame streaming ----
    lsfb_back #(.MAX_LEDS(MAX_LEDS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_led_count  (r_led_count),
        .i_job_valid  (job_valid),
        .i_job        (job),
        .o_job_pop    (job_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_frame_word (o_frame_word),
        .o_last_word  (o_last_word)
    );

    // ---- assertions ----
    // the flagged word of a frame is always the end word
    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last_word) |-> (o_frame_word == lsfb_pkg::END_WORD))
        else $error("last word is not the end word");

    // unflagged non-start words carry the LED header bits
    a_led_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_last_word && o_frame_word != lsfb_pkg::START_WORD) |->
        (o_frame_word[31:29] == 3'b111))
        else $error("LED word without header");

    // both queues come out of reset empty
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // led_count never exceeds the store size
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(cfg_wr) |-> (r_led_count <= MAX_CNT))
        else $error("led_count above store size");

endmodule
`default_nettype wire

[tb/tb_led_string_frame_builder.sv]
`default_nettype none

module tb_led_string_frame_builder;
    timeunit 1ns;
    timeprecision 1ps;

    import lsfb_pkg::*;

    // ------------------------------------------------------------------
    // Run constants
    // ------------------------------------------------------------------
    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 11;
    // Longest back-end job: a global update plus a frame, with the 2-deep
    // front queue full behind it. Wait well past that before a register write.
    localparam int SETTLE_CYCLES  = 4 * MAX_LEDS_DEF + 20;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SEGMENTS       = 8;
    localparam int SEGMENT_ITEMS  = 50;
    localparam int MAX_REPORTS    = 10;

    // Codes 6 and 7 are not defined by the block; they must be dropped.
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    // led_count sits at byte address 0 (register index 0)
    localparam logic [APB_ADDR_W-1:0] LED_COUNT_ADDR = {REG_LED_COUNT, 2'b00};

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [LED_IDX_W-1:0] led_index;
        logic [LEVEL_W-1:0]   red;
        logic [LEVEL_W-1:0]   green;
        logic [LEVEL_W-1:0]   blue;
        logic [LEVEL_W-1:0]   intensity;
        logic [BRI_W-1:0]     brightness;
        logic                 emit;
    } led_cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } frame_entry_t;

    // ------------------------------------------------------------------
    // DUT signals, the driven ones known from time zero
    // ------------------------------------------------------------------
    logic                  i_clk              = 1'b0;
    logic                  i_rst_n            = 1'b0;
    logic                  push               = 1'b0;
    logic                  full;
    logic [CMD_W-1:0]      i_command          = '0;
    logic [LED_IDX_W-1:0]  i_led_index        = '0;
    logic [LEVEL_W-1:0]    i_red_level        = '0;
    logic [LEVEL_W-1:0]    i_green_level      = '0;
    logic [LEVEL_W-1:0]    i_blue_level       = '0;
    logic [LEVEL_W-1:0]    i_intensity        = '0;
    logic [BRI_W-1:0]      i_brightness_level = '0;
    logic                  i_emit_frame       = 1'b0;
    logic                  empty;
    logic                  pop                = 1'b0;
    logic [WORD_W-1:0]     o_frame_word;
    logic                  o_last_word;
    logic                  psel               = 1'b0;
    logic                  penable            = 1'b0;
    logic                  pwrite             = 1'b0;
    logic [APB_ADDR_W-1:0] paddr              = '0;
    logic [APB_DATA_W-1:0] pwdata             = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    led_string_frame_builder DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_command          (i_command),
        .i_led_index        (i_led_index),
        .i_red_level        (i_red_level),
        .i_green_level      (i_green_level),
        .i_blue_level       (i_blue_level),
        .i_intensity        (i_intensity),
        .i_brightness_level (i_brightness_level),
        .i_emit_frame       (i_emit_frame),
        .empty              (empty),
        .pop                (pop),
        .o_frame_word       (o_frame_word),
        .o_last_word        (o_last_word),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // ------------------------------------------------------------------
    // Shadow of the LED store and the string length
    // ------------------------------------------------------------------
    logic [COLOUR_W-1:0] led_colour [MAX_LEDS_DEF] = '{default: '0};
    logic [BRI_W-1:0]    led_bri    [MAX_LEDS_DEF] = '{default: '0};
    int                  led_count  = MAX_LEDS_DEF;

    led_cmd_t     cmd_backlog[$];       // requests not yet taken by the block
    frame_entry_t frame_words_due[$];   // frame words still to come, oldest first

    int send_idle_pct = 17;
    int recv_idle_pct = 66;
    int mismatches    = 0;
    int cmds_taken    = 0;
    int words_checked = 0;
    int frames_seen   = 0;
    int reg_writes    = 0;
    int quiet_cycles  = 0;

    // ------------------------------------------------------------------
    // Predictor: applies one accepted request to the shadow store and
    // queues the frame it causes, if any.
    // ------------------------------------------------------------------
    task automatic apply_led_command(input led_cmd_t c);
        logic [15:0] scaled_r, scaled_g, scaled_b;
        logic        send_frame;
        logic        in_range;
        logic [7:0]  hdr;
        logic [COLOUR_W-1:0] rgb;
        send_frame = c.emit;
        in_range   = (int'(c.led_index) < led_count);
        scaled_r   = c.red   * c.intensity;
        scaled_g   = c.green * c.intensity;
        scaled_b   = c.blue  * c.intensity;
        case (c.command)
            CMD_SET_COLOUR: begin
                if (in_range) led_colour[c.led_index] = {c.red, c.green, c.blue};
            end
            CMD_SET_SCALED: begin
                if (in_range)
                    led_colour[c.led_index] = {scaled_r[15:8], scaled_g[15:8], scaled_b[15:8]};
            end
            CMD_SET_BRI: begin
                if (in_range) led_bri[c.led_index] = c.brightness;
            end
            CMD_ALL_BRI: begin
                // only entries below led_count; the rest keep their values
                for (int i = 0; i < led_count; i++) led_bri[i] = c.brightness;
            end
            CMD_ALL_COLOUR: begin
                for (int i = 0; i < led_count; i++)
                    led_colour[i] = {c.red, c.green, c.blue};
            end
            CMD_REFRESH: begin
                send_frame = 1'b1;
            end
            default: begin
                // spare codes: no update, no frame, emit flag ignored
                send_frame = 1'b0;
            end
        endcase
        if (send_frame) begin
            frame_words_due.push_back({START_WORD, 1'b0});
            for (int i = 0; i < led_count; i++) begin
                hdr = LED_HDR | {3'b000, led_bri[i]};
                rgb = led_colour[i];
                // wire order: header, blue, green, red
                frame_words_due.push_back({hdr, rgb[7:0], rgb[15:8], rgb[23:16], 1'b0});
            end
            frame_words_due.push_back({END_WORD, 1'b1});
        end
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH %s: expected %08h, got %08h", what, want, got);
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Request driver: takes the oldest backlog entry when the block accepts
    // the current request, then decides push for the next cycle. push gets
    // exactly one assignment per edge, so back-to-back requests stay high.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : request_driver
        logic offer;
        led_cmd_t nxt;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                apply_led_command(cmd_backlog.pop_front());
                cmds_taken++;
            end
            offer = (cmd_backlog.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct);
            push <= offer;
            if (offer) begin
                nxt = cmd_backlog[0];
                i_command          <= nxt.command;
                i_led_index        <= nxt.led_index;
                i_red_level        <= nxt.red;
                i_green_level      <= nxt.green;
                i_blue_level       <= nxt.blue;
                i_intensity        <= nxt.intensity;
                i_brightness_level <= nxt.brightness;
                i_emit_frame       <= nxt.emit;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks each popped word against the oldest one due.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : frame_monitor
        frame_entry_t want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (frame_words_due.size() == 0) begin
                    note_mismatch("frame word with nothing due", '0, o_frame_word);
                end else begin
                    want = frame_words_due.pop_front();
                    words_checked++;
                    if (want.last) frames_seen++;
                    if (o_frame_word !== want.word)
                        note_mismatch("frame_word", want.word, o_frame_word);
                    if (o_last_word !== want.last)
                        note_mismatch("last_word", 32'(want.last), 32'(o_last_word));
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any request, result or register access counts as progress.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (push && !full) || (pop && !empty) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_led_string_frame_builder: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic enqueue(input logic [CMD_W-1:0] cmd, input int idx,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic [7:0] inten, input int bri, input logic emit);
        cmd_backlog.push_back({cmd, LED_IDX_W'(idx), r, g, b, inten, BRI_W'(bri), emit});
    endtask

    task automatic enqueue_random();
        led_cmd_t c;
        int pick;
        pick = $urandom_range(0, 99);
        if      (pick < 20) c.command = CMD_SET_COLOUR;
        else if (pick < 40) c.command = CMD_SET_SCALED;
        else if (pick < 55) c.command = CMD_SET_BRI;
        else if (pick < 65) c.command = CMD_ALL_BRI;
        else if (pick < 75) c.command = CMD_ALL_COLOUR;
        else if (pick < 92) c.command = CMD_REFRESH;
        else if (pick < 96) c.command = CMD_SPARE_LO;
        else                c.command = CMD_SPARE_HI;
        // mostly LEDs that exist, some anywhere in the index space
        if (led_count > 0 && $urandom_range(0, 9) < 7)
            c.led_index = LED_IDX_W'($urandom_range(0, led_count - 1));
        else
            c.led_index = LED_IDX_W'($urandom());
        c.red        = 8'($urandom());
        c.green      = 8'($urandom());
        c.blue       = 8'($urandom());
        c.intensity  = 8'($urandom());
        c.brightness = BRI_W'($urandom());
        c.emit       = ($urandom_range(0, 99) < 35);
        cmd_backlog.push_back(c);
    endtask

    // Block must be idle before led_count changes: everything taken, every
    // word out, and the back end given time to finish a silent update.
    task automatic drain_and_settle();
        while (cmd_backlog.size() != 0 || frame_words_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_led_count(input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LED_COUNT_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // 6-bit field, saturates at the string maximum
        led_count = (int'(value[5:0]) > MAX_LEDS_DEF) ? MAX_LEDS_DEF : int'(value[5:0]);
        reg_writes++;
    endtask

    task automatic check_led_count();
        logic [31:0] got;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= LED_COUNT_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== 32'(led_count)) note_mismatch("led_count readback", 32'(led_count), got);
    endtask

    task automatic configure(input logic [31:0] value);
        drain_and_settle();
        write_led_count(value);
        check_led_count();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : test_sequence
        logic [31:0] cfg;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset value of the string length
        check_led_count();

        // Directed, full string of 32
        enqueue(CMD_REFRESH,    0,  8'h00, 8'h00, 8'h00, 8'h00, 0,  1'b0); // all-zero store
        enqueue(CMD_SET_COLOUR, 0,  8'hFF, 8'hFF, 8'hFF, 8'h00, 0,  1'b0);
        enqueue(CMD_SET_COLOUR, 31, 8'h12, 8'h34, 8'h56, 8'h00, 0,  1'b1);
        enqueue(CMD_SET_SCALED, 1,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 0,  1'b0); // full scale
        enqueue(CMD_SET_SCALED, 2,  8'hFF, 8'h80, 8'h01, 8'h00, 0,  1'b0); // zero scale
        enqueue(CMD_SET_SCALED, 3,  8'hFF, 8'hFF, 8'h01, 8'h80, 0,  1'b1);
        enqueue(CMD_SET_BRI,    0,  8'h00, 8'h00, 8'h00, 8'h00, 31, 1'b0);
        enqueue(CMD_SET_BRI,    31, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0,  1'b1);
        enqueue(CMD_ALL_BRI,    0,  8'h00, 8'h00, 8'h00, 8'h00, 31, 1'b0);
        enqueue(CMD_ALL_COLOUR, 0,  8'hAA, 8'h55, 8'hFF, 8'h00, 0,  1'b1);
        enqueue(CMD_SPARE_LO,   4,  8'h01, 8'h02, 8'h03, 8'h04, 5,  1'b1); // dropped
        enqueue(CMD_SPARE_HI,   4,  8'h01, 8'h02, 8'h03, 8'h04, 5,  1'b0);
        enqueue(CMD_SPARE_HI,   7,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 31, 1'b1);
        enqueue(CMD_SET_COLOUR, 5,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 31, 1'b1);

        // Short string: indices at and above the count are ignored
        configure(32'd5);
        enqueue(CMD_SET_COLOUR, 31, 8'h77, 8'h77, 8'h77, 8'h00, 0,  1'b1);
        enqueue(CMD_SET_BRI,    5,  8'h00, 8'h00, 8'h00, 8'h00, 9,  1'b0); // first out of range
        enqueue(CMD_SET_SCALED, 4,  8'h90, 8'h40, 8'hFF, 8'hC0, 0,  1'b0);
        enqueue(CMD_ALL_COLOUR, 0,  8'h11, 8'h22, 8'h33, 8'h00, 0,  1'b0);
        enqueue(CMD_ALL_BRI,    0,  8'h00, 8'h00, 8'h00, 8'h00, 7,  1'b1);

        // Empty string: frames are start and end word only
        configure(32'd0);
        enqueue(CMD_ALL_COLOUR, 0,  8'hDE, 8'hAD, 8'hBE, 8'h00, 0,  1'b0);
        enqueue(CMD_ALL_BRI,    0,  8'h00, 8'h00, 8'h00, 8'h00, 3,  1'b0);
        enqueue(CMD_SET_COLOUR, 0,  8'h01, 8'h01, 8'h01, 8'h00, 0,  1'b1);
        enqueue(CMD_REFRESH,    0,  8'h00, 8'h00, 8'h00, 8'h00, 0,  1'b0);

        // Back to 32: entries past the short string kept their old values
        configure(32'd32);
        enqueue(CMD_REFRESH,    0,  8'h00, 8'h00, 8'h00, 8'h00, 0,  1'b1);

        // Random segments, each with its own string length and idling mix
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0:       cfg = 32'd32;
                1:       cfg = 32'd1;
                2:       cfg = 32'($urandom_range(2, 31));
                3:       cfg = 32'd0;
                4:       cfg = 32'd63;            // saturates
                5:       cfg = $urandom();        // junk in the upper bits
                6:       cfg = 32'd17;
                default: cfg = 32'($urandom_range(1, 32));
            endcase
            configure(cfg);
            if (seg == 3) begin
                send_idle_pct <= 66;
                recv_idle_pct <= 17;
            end else if (seg == 6) begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            if (seg == 4) begin
                // sender holds off until every word due has been popped
                repeat (SEGMENT_ITEMS / 2) enqueue_random();
                while (cmd_backlog.size() != 0 || frame_words_due.size() != 0)
                    @(posedge i_clk);
                repeat (SEGMENT_ITEMS - SEGMENT_ITEMS / 2) enqueue_random();
            end else begin
                repeat (SEGMENT_ITEMS) enqueue_random();
            end
        end

        drain_and_settle();

        $display("Covered: %0d requests, %0d frames (%0d words), %0d led_count writes.",
                 cmds_taken, frames_seen, words_checked, reg_writes);
        $display("String lengths 0, 1, 5, 17, 32, saturated and random; idling on each side and none.");
        if (mismatches == 0 && frame_words_due.size() == 0) begin
            $display("tb_led_string_frame_builder: done, clean");
        end else begin
            $display("tb_led_string_frame_builder: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
